@@ hdl/prc_pkg.sv @@
`timescale 1ns / 1ps

package prc_pkg;

  // Conversion kinds carried by each item.
  localparam logic [1:0] KIND_NAV  = 2'd0;
  localparam logic [1:0] KIND_MATH = 2'd1;
  localparam logic [1:0] KIND_RECT = 2'd2;

  // Angle accumulator counts 2^-32 turn, one guard bit above the sign.
  localparam int ACC_W = 33;

  // CORDIC gain compensation, 0.60725293500888 in Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic [1:0] kind;
    logic       origin;
    logic       half_turn;
  } ctrl_t;

  // atan(2^-idx) in 2^-32 turn, rounded to nearest.
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      24:      val = 32'd41;
      25:      val = 32'd20;
      26:      val = 32'd10;
      27:      val = 32'd5;
      28:      val = 32'd3;
      29:      val = 32'd1;
      30:      val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/prc_prep.sv @@
`timescale 1ns / 1ps

module prc_prep #(
  parameter int CW = 24,
  parameter int AW = 16,
  parameter int ZW = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic [1:0]                        kind_i,
  input  logic [CW-2:0]                     magnitude_i,
  input  logic [AW-1:0]                     angle_i,
  input  logic signed [CW-1:0]              coord_x_i,
  input  logic signed [CW-1:0]              coord_y_i,
  output logic                              valid_o,
  output prc_pkg::ctrl_t                    ctrl_o,
  output logic signed [ZW-1:0]              x_o,
  output logic signed [ZW-1:0]              y_o,
  output logic signed [prc_pkg::ACC_W-1:0]  z_o
);

  localparam int PW = CW + 29;
  localparam logic [PW:0] RND14 = {{(PW-13){1'b0}}, 1'b1, 13'd0};

  logic [31:0]           a32;
  logic                  reduce;
  logic [PW-1:0]         prod;
  logic signed [ZW-1:0]  px_w, py_w, u_w, w_w;
  logic                  flip, origin;

  logic                  v1_r;
  prc_pkg::ctrl_t        ctrl1_r;
  logic [PW-1:0]         prod1_r;
  logic                  neg1_r;
  logic [31:0]           ang1_r;
  logic signed [ZW-1:0]  u1_r, w1_r;

  logic signed [PW:0]    pe, pt, psh;
  logic                  rect1;
  logic signed [ZW-1:0]  x_nxt, y_nxt;
  logic signed [prc_pkg::ACC_W-1:0] z_nxt;

  logic                  v2_r;
  prc_pkg::ctrl_t        ctrl2_r;
  logic signed [ZW-1:0]  x2_r, y2_r;
  logic signed [prc_pkg::ACC_W-1:0] z2_r;

  // Angles whose top two bits differ lie outside a quarter turn of zero:
  // turn them by half a turn and start from the negated vector.
  assign a32    = {angle_i, (32-AW)'(0)};
  assign reduce = a32[31] ^ a32[30];
  assign prod   = PW'(magnitude_i) * PW'(prc_pkg::GAIN_Q30);

  assign px_w   = {{(ZW-CW-16){coord_x_i[CW-1]}}, coord_x_i, 16'd0};
  assign py_w   = {{(ZW-CW-16){coord_y_i[CW-1]}}, coord_y_i, 16'd0};
  assign flip   = coord_y_i[CW-1];
  assign u_w    = flip ? -py_w : py_w;
  assign w_w    = flip ? -px_w : px_w;
  assign origin = (coord_x_i == '0) && (coord_y_i == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl1_r <= '{kind: kind_i, origin: origin, half_turn: flip};
      prod1_r <= prod;
      neg1_r  <= reduce;
      ang1_r  <= {a32[31] ^ reduce, a32[30:0]};
      u1_r    <= u_w;
      w1_r    <= w_w;
    end
  end

  // Rounded Q16 start value; the negated case rounds the magnitude and then
  // negates it, which folds into adding to the complement.
  assign pe    = $signed({1'b0, prod1_r});
  assign pt    = (neg1_r ? ~pe : pe) + $signed(RND14);
  assign psh   = pt >>> 14;
  assign rect1 = (ctrl1_r.kind == prc_pkg::KIND_RECT);

  assign x_nxt = rect1 ? u1_r : psh[ZW-1:0];
  assign y_nxt = rect1 ? w1_r : '0;
  assign z_nxt = rect1 ? '0 : {ang1_r[31], ang1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl2_r <= ctrl1_r;
      x2_r    <= x_nxt;
      y2_r    <= y_nxt;
      z2_r    <= z_nxt;
    end
  end

  assign valid_o = v2_r;
  assign ctrl_o  = ctrl2_r;
  assign x_o     = x2_r;
  assign y_o     = y2_r;
  assign z_o     = z2_r;

endmodule

@@ hdl/prc_cordic_stage.sv @@
`timescale 1ns / 1ps

module prc_cordic_stage #(
  parameter int ZW    = 42,
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  prc_pkg::ctrl_t                    ctrl_i,
  input  logic signed [ZW-1:0]              x_i,
  input  logic signed [ZW-1:0]              y_i,
  input  logic signed [prc_pkg::ACC_W-1:0]  z_i,
  output logic                              valid_o,
  output prc_pkg::ctrl_t                    ctrl_o,
  output logic signed [ZW-1:0]              x_o,
  output logic signed [ZW-1:0]              y_o,
  output logic signed [prc_pkg::ACC_W-1:0]  z_o
);

  localparam logic signed [prc_pkg::ACC_W-1:0] ATAN_STEP =
    $signed({1'b0, prc_pkg::atan_turn(STAGE)});

  logic                  sigma_pos;
  logic signed [ZW-1:0]  xs, ys;

  logic                  valid_r;
  prc_pkg::ctrl_t        ctrl_r;
  logic signed [ZW-1:0]  x_r, y_r;
  logic signed [prc_pkg::ACC_W-1:0] z_r;

  // Rotation drives the angle to zero, vectoring drives y to zero.
  assign sigma_pos = (ctrl_i.kind == prc_pkg::KIND_RECT) ? y_i[ZW-1] : !z_i[prc_pkg::ACC_W-1];
  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_i;
      if (sigma_pos) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ATAN_STEP;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ATAN_STEP;
      end
    end
  end

  assign valid_o = valid_r;
  assign ctrl_o  = ctrl_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;

endmodule

@@ hdl/prc_post.sv @@
`timescale 1ns / 1ps

module prc_post #(
  parameter int CW = 24,
  parameter int AW = 16,
  parameter int ZW = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  prc_pkg::ctrl_t                    ctrl_i,
  input  logic signed [ZW-1:0]              x_i,
  input  logic signed [ZW-1:0]              y_i,
  input  logic signed [prc_pkg::ACC_W-1:0]  z_i,
  output logic                              valid_o,
  output logic signed [CW-1:0]              x_o,
  output logic signed [CW-1:0]              y_o,
  output logic [CW-1:0]                     distance_o,
  output logic [AW-1:0]                     bearing_o
);

  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam int RES_W   = 24;          // residual angle after the last step
  localparam int RQ_W    = 32;          // residual in radians, Q37
  localparam int PZ_W    = RES_W + 32;
  localparam int SPLIT_W = 20;
  localparam int HP_W    = ZW - SPLIT_W + 32;
  localparam int LP_W    = SPLIT_W + 33;
  localparam int MW      = ZW + 32;
  localparam int FW      = ZW + 1;
  localparam int SH_P    = 37;
  localparam int SH_R    = 46;

  localparam logic [PZ_W-1:0] HALF_Z   = PZ_W'(1) << 22;
  localparam logic [PZ_W-1:0] HALF_Z_N = HALF_Z - PZ_W'(1);
  localparam logic [MW-1:0]   HALF_P   = MW'(1) << (SH_P - 1);
  localparam logic [MW-1:0]   HALF_P_N = HALF_P - MW'(1);
  localparam logic [MW-1:0]   HALF_R   = MW'(1) << (SH_R - 1);
  localparam logic [MW-1:0]   HALF_R_N = HALF_R - MW'(1);
  localparam logic [FW-1:0]   HALF_16   = FW'(32'd32768);
  localparam logic [FW-1:0]   HALF_16_N = FW'(32'd32767);
  localparam logic signed [FW-1:0] SAT_HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [FW-1:0] SAT_LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Q16 to output units, ties away from zero, clipped to the signed range.
  function automatic logic [CW-1:0] round_sat(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] t;
    logic signed [FW-1:0] r;
    logic [CW-1:0]        res;
    t = v + $signed(v[FW-1] ? HALF_16_N : HALF_16);
    r = t >>> 16;
    if (r > SAT_HI) begin
      res = SAT_HI[CW-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[CW-1:0];
    end else begin
      res = r[CW-1:0];
    end
    return res;
  endfunction

  // Stage 1: residual angle times 2*pi, bearing rounding.
  logic signed [RES_W-1:0] zres;
  logic signed [PZ_W-1:0]  pz;
  logic [32:0]             bsum;

  logic                    v1_r;
  prc_pkg::ctrl_t          c1_r;
  logic signed [ZW-1:0]    x1_r, y1_r;
  logic signed [PZ_W-1:0]  pz1_r;
  logic [AW-1:0]           bear1_r;

  assign zres = z_i[RES_W-1:0];
  assign pz   = $signed(zres) * $signed({1'b0, TWO_PI_Q28});
  assign bsum = {1'b0, z_i[31] ^ ctrl_i.half_turn, z_i[30:0]} + (33'd1 << (31 - AW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= ctrl_i;
      x1_r    <= x_i;
      y1_r    <= y_i;
      pz1_r   <= pz;
      bear1_r <= bsum[31:32-AW];
    end
  end

  // Stage 2: residual in radians, Q37.
  logic signed [PZ_W-1:0]  pz_t, pz_sh;

  logic                    v2_r;
  prc_pkg::ctrl_t          c2_r;
  logic signed [ZW-1:0]    x2_r, y2_r;
  logic signed [RQ_W-1:0]  rq2_r;
  logic [AW-1:0]           bear2_r;

  assign pz_t  = pz1_r + $signed(pz1_r[PZ_W-1] ? HALF_Z_N : HALF_Z);
  assign pz_sh = pz_t >>> 23;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      rq2_r   <= pz_sh[RQ_W-1:0];
      bear2_r <= bear1_r;
    end
  end

  // Stage 3: partial products. Lane A forms y*rq, or x*gain for vectoring;
  // lane B forms x*rq.
  logic                    rect2;
  logic signed [ZW-1:0]    opa;
  logic signed [RQ_W-1:0]  opb_a;
  logic signed [HP_W-1:0]  hia, hib;
  logic signed [LP_W-1:0]  loa, lob;

  logic                    v3_r;
  prc_pkg::ctrl_t          c3_r;
  logic signed [ZW-1:0]    x3_r, y3_r;
  logic signed [HP_W-1:0]  hia3_r, hib3_r;
  logic signed [LP_W-1:0]  loa3_r, lob3_r;
  logic [AW-1:0]           bear3_r;

  assign rect2 = (c2_r.kind == prc_pkg::KIND_RECT);
  assign opa   = rect2 ? x2_r : y2_r;
  assign opb_a = rect2 ? $signed({2'b00, prc_pkg::GAIN_Q30}) : rq2_r;
  assign hia   = $signed(opa[ZW-1:SPLIT_W]) * opb_a;
  assign loa   = $signed({1'b0, opa[SPLIT_W-1:0]}) * opb_a;
  assign hib   = $signed(x2_r[ZW-1:SPLIT_W]) * rq2_r;
  assign lob   = $signed({1'b0, x2_r[SPLIT_W-1:0]}) * rq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r    <= c2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      hia3_r  <= hia;
      loa3_r  <= loa;
      hib3_r  <= hib;
      lob3_r  <= lob;
      bear3_r <= bear2_r;
    end
  end

  // Stage 4: recombine the partial products.
  logic signed [MW-1:0]    pa, pb;

  logic                    v4_r;
  prc_pkg::ctrl_t          c4_r;
  logic signed [ZW-1:0]    x4_r, y4_r;
  logic signed [MW-1:0]    pa4_r, pb4_r;
  logic [AW-1:0]           bear4_r;

  assign pa = (MW'(hia3_r) <<< SPLIT_W) + MW'(loa3_r);
  assign pb = (MW'(hib3_r) <<< SPLIT_W) + MW'(lob3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r    <= c3_r;
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      pa4_r   <= pa;
      pb4_r   <= pb;
      bear4_r <= bear3_r;
    end
  end

  // Stage 5: round the products, ties away from zero.
  logic                    rect4;
  logic [MW-1:0]           adda, addb;
  logic signed [MW-1:0]    ta, tb, sha, shb;

  logic                    v5_r;
  prc_pkg::ctrl_t          c5_r;
  logic signed [ZW-1:0]    x5_r, y5_r, ra5_r, rb5_r;
  logic [AW-1:0]           bear5_r;

  assign rect4 = (c4_r.kind == prc_pkg::KIND_RECT);
  assign adda  = rect4 ? (pa4_r[MW-1] ? HALF_R_N : HALF_R)
                       : (pa4_r[MW-1] ? HALF_P_N : HALF_P);
  assign addb  = pb4_r[MW-1] ? HALF_P_N : HALF_P;
  assign ta    = pa4_r + $signed(adda);
  assign tb    = pb4_r + $signed(addb);
  assign sha   = rect4 ? (ta >>> SH_R) : (ta >>> SH_P);
  assign shb   = tb >>> SH_P;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r    <= c4_r;
      x5_r    <= x4_r;
      y5_r    <= y4_r;
      ra5_r   <= sha[ZW-1:0];
      rb5_r   <= shb[ZW-1:0];
      bear5_r <= bear4_r;
    end
  end

  // Stage 6: first-order rotation by the residual angle.
  logic                    v6_r;
  prc_pkg::ctrl_t          c6_r;
  logic signed [FW-1:0]    xf6_r, yf6_r;
  logic signed [ZW-1:0]    dist6_r;
  logic [AW-1:0]           bear6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6_r    <= c5_r;
      xf6_r   <= FW'(x5_r) - FW'(ra5_r);
      yf6_r   <= FW'(y5_r) + FW'(rb5_r);
      dist6_r <= ra5_r;
      bear6_r <= bear5_r;
    end
  end

  // Stage 7: output register.
  logic [CW-1:0]           cos_part, sin_part, dist_sat;
  logic signed [CW-1:0]    ox_nxt, oy_nxt;
  logic [CW-1:0]           od_nxt;
  logic [AW-1:0]           ob_nxt;

  logic                    valid_r;
  logic signed [CW-1:0]    ox_r, oy_r;
  logic [CW-1:0]           od_r;
  logic [AW-1:0]           ob_r;

  assign cos_part = round_sat(xf6_r);
  assign sin_part = round_sat(yf6_r);

  always_comb begin
    if (dist6_r[ZW-1]) begin
      dist_sat = '0;
    end else if (|dist6_r[ZW-2:CW]) begin
      dist_sat = '1;
    end else begin
      dist_sat = dist6_r[CW-1:0];
    end
  end

  always_comb begin
    ox_nxt = '0;
    oy_nxt = '0;
    od_nxt = '0;
    ob_nxt = '0;
    case (c6_r.kind)
      prc_pkg::KIND_NAV: begin
        ox_nxt = sin_part;
        oy_nxt = cos_part;
      end
      prc_pkg::KIND_MATH: begin
        ox_nxt = cos_part;
        oy_nxt = sin_part;
      end
      prc_pkg::KIND_RECT: begin
        // The origin has no direction; report zero for both fields.
        if (!c6_r.origin) begin
          od_nxt = dist_sat;
          ob_nxt = bear6_r;
        end
      end
      default: begin
        ox_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      od_r <= od_nxt;
      ob_r <= ob_nxt;
    end
  end

  assign valid_o    = valid_r;
  assign x_o        = ox_r;
  assign y_o        = oy_r;
  assign distance_o = od_r;
  assign bearing_o  = ob_r;

endmodule

@@ hdl/polar_rect_converter.sv @@
`timescale 1ns / 1ps
// Stages from input accept to output valid: 2 set-up stages, one register
// stage per CORDIC step, 7 rescaling stages.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output register with out_ready low.
// Reset: synchronous, active low; clears every stage's valid bit only.
module polar_rect_converter #(
  parameter int COORD_WIDTH    = 24,
  parameter int ANGLE_WIDTH    = 16,
  parameter int ROTATION_STEPS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [COORD_WIDTH-2:0]   in_magnitude,
  input  logic [ANGLE_WIDTH-1:0]   in_angle,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic [COORD_WIDTH-1:0]   out_distance,
  output logic [ANGLE_WIDTH-1:0]   out_bearing
);

  localparam int NS = (ROTATION_STEPS < 8) ? 8 :
                      ((ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS);
  // Q16 fraction, CORDIC growth and a sign bit above the coordinate width.
  localparam int GUARD_W = 18;
  localparam int ZW      = COORD_WIDTH + GUARD_W;

  logic en;

  logic                              sv [0:NS];
  prc_pkg::ctrl_t                    sc [0:NS];
  logic signed [ZW-1:0]              sx [0:NS];
  logic signed [ZW-1:0]              sy [0:NS];
  logic signed [prc_pkg::ACC_W-1:0]  sz [0:NS];

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  prc_prep #(
    .CW (COORD_WIDTH),
    .AW (ANGLE_WIDTH),
    .ZW (ZW)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .valid_i     (in_valid),
    .kind_i      (in_kind),
    .magnitude_i (in_magnitude),
    .angle_i     (in_angle),
    .coord_x_i   (in_coord_x),
    .coord_y_i   (in_coord_y),
    .valid_o     (sv[0]),
    .ctrl_o      (sc[0]),
    .x_o         (sx[0]),
    .y_o         (sy[0]),
    .z_o         (sz[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_step
    prc_cordic_stage #(
      .ZW    (ZW),
      .STAGE (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sv[i]),
      .ctrl_i  (sc[i]),
      .x_i     (sx[i]),
      .y_i     (sy[i]),
      .z_i     (sz[i]),
      .valid_o (sv[i+1]),
      .ctrl_o  (sc[i+1]),
      .x_o     (sx[i+1]),
      .y_o     (sy[i+1]),
      .z_o     (sz[i+1])
    );
  end

  prc_post #(
    .CW (COORD_WIDTH),
    .AW (ANGLE_WIDTH),
    .ZW (ZW)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_i    (sv[NS]),
    .ctrl_i     (sc[NS]),
    .x_i        (sx[NS]),
    .y_i        (sy[NS]),
    .z_i        (sz[NS]),
    .valid_o    (out_valid),
    .x_o        (out_x),
    .y_o        (out_y),
    .distance_o (out_distance),
    .bearing_o  (out_bearing)
  );

endmodule

@@ hdl/prc_checker.sv @@
`timescale 1ns / 1ps

module prc_checker #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic [COORD_WIDTH-1:0]        out_distance,
  input logic [ANGLE_WIDTH-1:0]        out_bearing
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_distance) && $stable(out_bearing))
    else $error("result changed while stalled");

  // Input is taken whenever the output register is free or draining.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with a free output");

  // A polar result never carries rectangular fields, and the reverse.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_distance != '0 || out_bearing != '0) |-> out_x == '0 && out_y == '0)
    else $error("polar and rectangular fields both set");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Otherwise unused: keeps the input handshake visible to the checker.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |-> 1'b0)
    else $error("item accepted during an output stall");

endmodule

bind polar_rect_converter prc_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_prc_checker (.*);

@@ tb/sv/prc_point_checker.sv @@
`timescale 1ns / 1ps
module prc_point_checker #(
  parameter int COORD_WIDTH    = 24,
  parameter int ANGLE_WIDTH    = 16,
  parameter int ROTATION_STEPS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [COORD_WIDTH-2:0]        in_magnitude,
  input  logic [ANGLE_WIDTH-1:0]        in_angle,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [COORD_WIDTH-1:0] out_x,
  input  logic signed [COORD_WIDTH-1:0] out_y,
  input  logic [COORD_WIDTH-1:0]        out_distance,
  input  logic [ANGLE_WIDTH-1:0]        out_bearing,
  output int                            mismatch_count,
  output int                            outstanding
);

  localparam int STEP_N = (ROTATION_STEPS < 8) ? 8 :
                          ((ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS);
  localparam longint GAIN         = 64'sd652032874;
  localparam longint TWO_PI_Q28   = 64'sd1686629713;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam longint COORD_MAX    = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN    = -(64'sd1 <<< (COORD_WIDTH - 1));
  localparam longint DIST_MAX     = (64'sd1 <<< COORD_WIDTH) - 1;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0]        distance;
    logic [ANGLE_WIDTH-1:0]        bear;
  } point_result_t;

  point_result_t converted_q[$];
  longint        atan_lut[32];

  // Arctangent of 2^-i in units of 2^-32 turn.
  initial begin
    atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                 10, 5, 3, 1, 1, 0};
  end

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic longint shift_round(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // a*b / 2^s with the same rounding, split so that no product overflows.
  function automatic longint scale_round(longint a, longint b, int s);
    bit              neg;
    longint unsigned ua, ub, hi, lo, q, r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    hi  = ua >> 31;
    lo  = ua & 64'h7FFF_FFFF;
    q   = hi * ub + ((lo * ub) >> 31);
    r   = (q + (64'd1 << (s - 32))) >> (s - 31);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic point_result_t convert_point(
      logic [1:0] kind, logic [COORD_WIDTH-2:0] mag, logic [ANGLE_WIDTH-1:0] ang,
      logic signed [COORD_WIDTH-1:0] cx, logic signed [COORD_WIDTH-1:0] cy);
    point_result_t   res;
    logic [31:0]     a, base;
    longint          x, y, z, xs, ys, rq, dx, dy, cos_part, sin_part, dd;
    longint unsigned bear;
    res = '{x: '0, y: '0, distance: '0, bear: '0};
    if (kind == prc_pkg::KIND_NAV || kind == prc_pkg::KIND_MATH) begin
      a = 32'(ang) << (32 - ANGLE_WIDTH);
      x = shift_round(longint'(mag) * GAIN, 14);
      y = 0;
      // Fold the angle into the quarter turn either side of zero.
      if (((a + QUARTER) & HALF) != 0) begin
        x = -x;
        a = a - HALF;
      end
      z = longint'($signed(a));
      for (int i = 0; i < STEP_N; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_lut[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_lut[i];
        end
      end
      // The residual angle is applied as a small first-order rotation.
      rq = shift_round(z * TWO_PI_Q28, 23);
      dx = scale_round(y, rq, 37);
      dy = scale_round(x, rq, 37);
      x  = x - dx;
      y  = y + dy;
      cos_part = clip_coord(shift_round(x, 16));
      sin_part = clip_coord(shift_round(y, 16));
      if (kind == prc_pkg::KIND_NAV) begin
        res.x = sin_part[COORD_WIDTH-1:0];
        res.y = cos_part[COORD_WIDTH-1:0];
      end else begin
        res.x = cos_part[COORD_WIDTH-1:0];
        res.y = sin_part[COORD_WIDTH-1:0];
      end
    end else if (kind == prc_pkg::KIND_RECT && !(cx == 0 && cy == 0)) begin
      x    = longint'(cy) * 65536;
      y    = longint'(cx) * 65536;
      z    = 0;
      base = '0;
      if (x < 0) begin
        x    = -x;
        y    = -y;
        base = HALF;
      end
      for (int i = 0; i < STEP_N; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_lut[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_lut[i];
        end
      end
      a    = base + z[31:0];
      bear = ({32'd0, a} + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH);
      dd   = scale_round(x, GAIN, 46);
      if (dd < 0) dd = 0;
      if (dd > DIST_MAX) dd = DIST_MAX;
      res.distance = dd[COORD_WIDTH-1:0];
      res.bear     = bear[ANGLE_WIDTH-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    point_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        converted_q.push_back(convert_point(in_kind, in_magnitude, in_angle,
                                            in_coord_x, in_coord_y));
      if (out_valid && out_ready) begin
        if (converted_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = converted_q.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (out_distance !== want.distance)
            report_mismatch("out_distance", out_distance, want.distance);
          if (out_bearing !== want.bear)
            report_mismatch("out_bearing", out_bearing, want.bear);
        end
      end
    end
    outstanding <= converted_q.size();
  end

endmodule

@@ tb/sv/polar_rect_converter_tb.sv @@
`timescale 1ns / 1ps
module polar_rect_converter_tb;

  localparam int COORD_W       = 24;
  localparam int ANGLE_W       = 16;
  localparam int STEPS         = 20;
  localparam int PIPE_DEPTH    = STEPS + 9;
  localparam int RANDOM_POINTS = 540;
  localparam int HOLD_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 60000;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [COORD_W-2:0] MAG_MAX = '1;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_kind      = '0;
  logic [COORD_W-2:0]        in_magnitude = '0;
  logic [ANGLE_W-1:0]        in_angle     = '0;
  logic signed [COORD_W-1:0] in_coord_x   = '0;
  logic signed [COORD_W-1:0] in_coord_y   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [COORD_W-1:0]        out_distance;
  logic [ANGLE_W-1:0]        out_bearing;

  logic hold_off      = 1'b0;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 75;
  int   phase         = 1;
  int   cycle_count   = 0;
  int   mismatch_count;
  int   outstanding;

  polar_rect_converter #(
    .COORD_WIDTH    (COORD_W),
    .ANGLE_WIDTH    (ANGLE_W),
    .ROTATION_STEPS (STEPS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_magnitude (in_magnitude),
    .in_angle     (in_angle),
    .in_coord_x   (in_coord_x),
    .in_coord_y   (in_coord_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_distance (out_distance),
    .out_bearing  (out_bearing)
  );

  prc_point_checker #(
    .COORD_WIDTH    (COORD_W),
    .ANGLE_WIDTH    (ANGLE_W),
    .ROTATION_STEPS (STEPS)
  ) u_point_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_magnitude   (in_magnitude),
    .in_angle       (in_angle),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_distance   (out_distance),
    .out_bearing    (out_bearing),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("polar_rect_converter_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long output stall while the sender runs flat out, so the pipeline fills.
  initial begin
    wait (phase == 3);
    repeat (10) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [COORD_W-2:0] rand_mag();
    return (COORD_W-1)'($urandom);
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_ang();
    return ANGLE_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  task automatic offer_point(logic [1:0] kind, logic [COORD_W-2:0] mag,
                             logic [ANGLE_W-1:0] ang, logic signed [COORD_W-1:0] cx,
                             logic signed [COORD_W-1:0] cy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_magnitude <= mag;
    in_angle     <= ang;
    in_coord_x   <= cx;
    in_coord_y   <= cy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic offer_random_point;
    logic [1:0]                kind;
    logic [COORD_W-2:0]        mag;
    logic [ANGLE_W-1:0]        ang;
    logic signed [COORD_W-1:0] cx, cy;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 32)      kind = prc_pkg::KIND_NAV;
    else if (pick < 62) kind = prc_pkg::KIND_MATH;
    else if (pick < 96) kind = prc_pkg::KIND_RECT;
    else                kind = KIND_SPARE;
    mag = rand_mag();
    case ($urandom_range(3))
      0:       mag = (COORD_W-1)'($urandom_range(255));
      1:       mag = MAG_MAX - (COORD_W-1)'($urandom_range(15));
      default: ;
    endcase
    ang = rand_ang();
    cx  = rand_coord();
    cy  = rand_coord();
    case ($urandom_range(5))
      0: begin
        cx = COORD_W'(int'($urandom_range(511)) - 256);
        cy = COORD_W'(int'($urandom_range(511)) - 256);
      end
      1:       cx = '0;
      2:       cy = '0;
      3:       cy = $urandom_range(1) ? C_MAX : C_MIN;
      default: ;
    endcase
    offer_point(kind, mag, ang, cx, cy);
  endtask

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    offer_point(prc_pkg::KIND_NAV, '0, '0, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, MAG_MAX, 16'h0000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, MAG_MAX, 16'h4000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, MAG_MAX, 16'h8000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, MAG_MAX, 16'hC000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, MAG_MAX, 16'h2000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_NAV, 23'd1, 16'h7FFF, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_MATH, MAG_MAX, 16'hFFFF, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_MATH, MAG_MAX, 16'h6000, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_MATH, 23'd12345, 16'h1234, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_MATH, 23'h2AAAAA, 16'hAAAA, rand_coord(), rand_coord());
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), '0, '0);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), C_MAX, C_MAX);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), C_MIN, C_MIN);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), C_MIN, C_MAX);
    // A hair left of +y rounds up to a full turn and must wrap to zero.
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), -24'sd1, C_MAX);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), '0, -24'sd5);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), 24'sd7, '0);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), -24'sd7, '0);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), C_MIN, '0);
    offer_point(prc_pkg::KIND_RECT, rand_mag(), rand_ang(), '0, C_MAX);
    offer_point(KIND_SPARE, MAG_MAX, '1, '1, '1);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n == RANDOM_POINTS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 6;
        phase         = 2;
      end else if (n == 2 * RANDOM_POINTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 3;
      end
      offer_random_point();
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("polar_rect_converter_tb: clean");
    end else begin
      $display("polar_rect_converter_tb: errors");
    end
    $finish;
  end

endmodule
